### rtl/assert_macros.svh
// Assertion macros used by the port checker of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define VLA_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define VLA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/vla_pkg.sv
// Package with the types, constants and tables of the vector length and azimuth block.
`default_nettype none

package vla_pkg;

    // Coordinate width and number of rotation steps.
    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 30;

    // Derived widths.
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int SQ_W       = 2 * COORD_WIDTH + 1;
    localparam int REM_W      = SQ_W + 1;
    localparam int ROOT_W     = COORD_WIDTH + 1;
    localparam int SQRT_STEPS = COORD_WIDTH + 1;
    localparam int NORM_BIT   = 57;
    localparam int NORM_W     = NORM_BIT + 1;
    localparam int XY_W       = NORM_W + 4;
    localparam int ANG_W      = 32;
    localparam int LEN_W      = 33;
    localparam int OUT_ANG_W  = 31;
    localparam int CORE_STEPS = (SQRT_STEPS > CORDIC_STAGES) ? SQRT_STEPS : CORDIC_STAGES;
    // Three front stages, the shared steps, three back stages.
    localparam int LATENCY    = CORE_STEPS + 6;

    // Angle mode register codes.
    localparam logic [1:0] MODE_LENGTH  = 2'd0;
    localparam logic [1:0] MODE_AZIMUTH = 2'd1;
    localparam logic [1:0] MODE_EAST    = 2'd2;
    localparam logic [1:0] MODE_RESET   = MODE_AZIMUTH;

    // Binary angles, one full turn is 2^32.
    localparam logic [ANG_W-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [ANG_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [ANG_W-1:0] TURN_3QUART  = 32'hC000_0000;

    // Scale factors to the output formats.
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [5:0]  DEG_MUL = 6'd45;

    // atan(2^-i) as a binary angle.
    localparam logic [ANG_W-1:0] ATAN_TURNS [40] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
    };

    // Input beat.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_start;
        logic signed [COORD_WIDTH-1:0] y_start;
        logic signed [COORD_WIDTH-1:0] x_end;
        logic signed [COORD_WIDTH-1:0] y_end;
    } vla_in_t;

    // Result beat.
    typedef struct packed {
        logic [LEN_W-1:0]     length;
        logic [OUT_ANG_W-1:0] angle_radians;
        logic [OUT_ANG_W-1:0] angle_degrees;
        logic                 degenerate;
    } vla_out_t;

    // Flags that travel beside the data through the pipeline.
    typedef struct packed {
        logic       degen;
        logic       dx_zero;
        logic       dy_neg;
        logic [1:0] mode;
    } side_t;

    // Working set of one shared step: root remainder and root, CORDIC vector and angle.
    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANG_W-1:0]       z;
    } stage_t;

endpackage

`default_nettype wire

### rtl/vector_length_azimuth_2d.sv
// Top level of the vector length and azimuth block.
`default_nettype none

// Usage:
// Drive a pair of points on item and raise start; a beat is taken at every
// rising edge with start high, and busy is always low, so a new beat may
// enter in every cycle. The length is rounded to nearest and, by angle_mode,
// the azimuth from north or the angle from east comes in radians and degrees.
// The result shows on result for exactly one cycle with done high, after
// three front stages, 33 shared square root and CORDIC steps and three back
// stages; in other modes both angles are zero. Throughput is one beat per cycle.
// The angle_mode register is written through cfg_valid and cfg_data;
// cfg_ready is always high. Write it only while no beat is in flight.
// Reset empties the pipeline, so no done follows reset until new beats
// enter, and sets angle_mode to azimuth. The receiver cannot stall: every
// result must be taken in the cycle that done is high.

module vector_length_azimuth_2d
    import vla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire vla_in_t    item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data,
    output logic            done,
    output vla_out_t        result
);

    logic [1:0] mode_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic   fr_valid, co_valid;
    stage_t fr_stage, co_stage;
    side_t  fr_side, co_side;

    vla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .item      (item),
        .mode      (mode_reg),
        .out_valid (fr_valid),
        .out_stage (fr_stage),
        .out_side  (fr_side)
    );

    vla_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stage  (fr_stage),
        .in_side   (fr_side),
        .out_valid (co_valid),
        .out_stage (co_stage),
        .out_side  (co_side)
    );

    vla_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (co_valid),
        .in_stage (co_stage),
        .in_side  (co_side),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

### rtl/vla_front.sv
// Front stages: differences, squares, normalization and the start of both iterations.
`default_nettype none

module vla_front
    import vla_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire vla_in_t item,
    input  wire logic [1:0] mode,
    output logic        out_valid,
    output stage_t      out_stage,
    output side_t       out_side
);

    // Stage one registers.
    logic                   v1_reg;
    logic [COORD_WIDTH-1:0] adx_reg, ady_reg;
    logic                   yneg_reg;
    logic [ANG_W-1:0]       z0_reg;
    side_t                  sd1_reg;

    // Stage two registers.
    logic                   v2_reg;
    logic [2*COORD_WIDTH-1:0] asq_reg, bsq_reg;
    logic [NORM_W-1:0]      axn2_reg, ayn2_reg, mn2_reg;
    logic                   yneg2_reg;
    logic [ANG_W-1:0]       z2_reg;
    side_t                  sd2_reg;

    // Stage three registers.
    logic                   v3_reg;
    stage_t                 st3_reg;
    side_t                  sd3_reg;

    // Stage one: signed differences and their magnitudes.
    logic signed [DIFF_W-1:0] dx, dy;
    logic [DIFF_W-1:0]        dx_abs, dy_abs;
    side_t                    sd1_next;

    always_comb
    begin
        dx = DIFF_W'(item.x_end) - DIFF_W'(item.x_start);
        dy = DIFF_W'(item.y_end) - DIFF_W'(item.y_start);
        dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        sd1_next.degen   = (dx == '0) && (dy == '0);
        sd1_next.dx_zero = (dx == '0);
        sd1_next.dy_neg  = dy[DIFF_W-1];
        sd1_next.mode    = mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // A negative dx turns the vector by a half turn; y sign follows.
    always_ff @(posedge clk)
    begin
        adx_reg  <= dx_abs[COORD_WIDTH-1:0];
        ady_reg  <= dy_abs[COORD_WIDTH-1:0];
        yneg_reg <= (dy != '0) && (dy[DIFF_W-1] ^ dx[DIFF_W-1]);
        z0_reg   <= dx[DIFF_W-1] ? TURN_HALF : '0;
        sd1_reg  <= sd1_next;
    end

    // Stage two: squares and the coarse part of the normalizing shift.
    logic [NORM_W-1:0] m_a, ax_a, ay_a;

    always_comb
    begin
        m_a  = NORM_W'((adx_reg > ady_reg) ? adx_reg : ady_reg);
        ax_a = NORM_W'(adx_reg);
        ay_a = NORM_W'(ady_reg);
        if (m_a[NORM_W-1 -: 32] == '0)
        begin
            m_a = m_a << 32; ax_a = ax_a << 32; ay_a = ay_a << 32;
        end
        if (m_a[NORM_W-1 -: 16] == '0)
        begin
            m_a = m_a << 16; ax_a = ax_a << 16; ay_a = ay_a << 16;
        end
        if (m_a[NORM_W-1 -: 8] == '0)
        begin
            m_a = m_a << 8; ax_a = ax_a << 8; ay_a = ay_a << 8;
        end
    end

    always_ff @(posedge clk)
    begin
        asq_reg   <= (2*COORD_WIDTH)'(adx_reg) * (2*COORD_WIDTH)'(adx_reg);
        bsq_reg   <= (2*COORD_WIDTH)'(ady_reg) * (2*COORD_WIDTH)'(ady_reg);
        mn2_reg   <= m_a;
        axn2_reg  <= ax_a;
        ayn2_reg  <= ay_a;
        yneg2_reg <= yneg_reg;
        z2_reg    <= z0_reg;
        sd2_reg   <= sd1_reg;
    end

    // Stage three: sum of squares, fine shift and signed start vector.
    logic [NORM_W-1:0] m_b, ax_b, ay_b;
    stage_t            st3_next;

    always_comb
    begin
        m_b  = mn2_reg;
        ax_b = axn2_reg;
        ay_b = ayn2_reg;
        if (m_b[NORM_W-1 -: 4] == '0)
        begin
            m_b = m_b << 4; ax_b = ax_b << 4; ay_b = ay_b << 4;
        end
        if (m_b[NORM_W-1 -: 2] == '0)
        begin
            m_b = m_b << 2; ax_b = ax_b << 2; ay_b = ay_b << 2;
        end
        if (m_b[NORM_W-1] == 1'b0)
        begin
            ax_b = ax_b << 1; ay_b = ay_b << 1;
        end
        st3_next.rem  = REM_W'(asq_reg) + REM_W'(bsq_reg);
        st3_next.root = '0;
        st3_next.x    = XY_W'(ax_b);
        st3_next.y    = yneg2_reg ? -XY_W'(ay_b) : XY_W'(ay_b);
        st3_next.z    = z2_reg;
    end

    always_ff @(posedge clk)
    begin
        st3_reg <= st3_next;
        sd3_reg <= sd2_reg;
    end

    assign out_valid = v3_reg;
    assign out_stage = st3_reg;
    assign out_side  = sd3_reg;

endmodule

`default_nettype wire

### rtl/vla_core.sv
// Shared steps: a square root bit each; the first CORDIC_STAGES also do a rotation.
`default_nettype none

module vla_core
    import vla_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire stage_t in_stage,
    input  wire side_t  in_side,
    output logic        out_valid,
    output stage_t      out_stage,
    output side_t       out_side
);

    logic   vld_reg [CORE_STEPS];
    stage_t stg_reg [CORE_STEPS];
    side_t  sd_reg  [CORE_STEPS];

    for (genvar k = 0; k < CORE_STEPS; k++)
    begin : g_step
        logic   cur_vld;
        stage_t cur;
        side_t  cur_sd;
        stage_t stg_next;

        // Source of this stage: the front end or the stage before.
        if (k == 0)
        begin : g_head
            assign cur_vld = in_valid;
            assign cur     = in_stage;
            assign cur_sd  = in_side;
        end
        else
        begin : g_link
            assign cur_vld = vld_reg[k-1];
            assign cur     = stg_reg[k-1];
            assign cur_sd  = sd_reg[k-1];
        end

        // One restoring square root bit, most significant first.
        if (k < SQRT_STEPS)
        begin : g_sqrt
            localparam int B = SQRT_STEPS - 1 - k;
            logic [REM_W-1:0] trial;
            assign trial = (REM_W'(cur.root) << (B + 1)) + (REM_W'(1) << (2 * B));
            assign stg_next.rem  = (cur.rem >= trial) ? cur.rem - trial : cur.rem;
            assign stg_next.root = (cur.rem >= trial) ? cur.root | (ROOT_W'(1) << B)
                                                      : cur.root;
        end
        else
        begin : g_sqrt_hold
            assign stg_next.rem  = cur.rem;
            assign stg_next.root = cur.root;
        end

        // One vectoring rotation driving y toward zero.
        if (k < CORDIC_STAGES)
        begin : g_rot
            logic signed [XY_W-1:0] xs, ys;
            logic                   pos;
            assign xs  = cur.x >>> k;
            assign ys  = cur.y >>> k;
            assign pos = !cur.y[XY_W-1] && (cur.y != '0);
            assign stg_next.x = pos ? cur.x + ys : cur.x - ys;
            assign stg_next.y = pos ? cur.y - xs : cur.y + xs;
            assign stg_next.z = pos ? cur.z + ATAN_TURNS[k] : cur.z - ATAN_TURNS[k];
        end
        else
        begin : g_rot_hold
            assign stg_next.x = cur.x;
            assign stg_next.y = cur.y;
            assign stg_next.z = cur.z;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            stg_reg[k] <= stg_next;
            sd_reg[k]  <= cur_sd;
        end
    end

    assign out_valid = vld_reg[CORE_STEPS-1];
    assign out_stage = stg_reg[CORE_STEPS-1];
    assign out_side  = sd_reg[CORE_STEPS-1];

endmodule

`default_nettype wire

### rtl/vla_back.sv
// Back stages: length rounding, angle selection and scaling to radians and degrees.
`default_nettype none

module vla_back
    import vla_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire stage_t in_stage,
    input  wire side_t  in_side,
    output logic        done,
    output vla_out_t    result
);

    logic             v1_reg, v2_reg, v3_reg;
    logic [LEN_W-1:0] len1_reg, len2_reg;
    logic [ANG_W-1:0] sel1_reg;
    side_t            sd1_reg, sd2_reg;
    logic [2*ANG_W-1:0] prad_reg;
    logic [37:0]        pdeg_reg;
    vla_out_t         res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Round the root up when the remainder exceeds it; pick the angle.
    logic [ANG_W-1:0] theta;
    always_comb
    begin
        if (in_side.dx_zero)
            theta = in_side.dy_neg ? TURN_3QUART : TURN_QUARTER;
        else
            theta = in_stage.z;
    end

    always_ff @(posedge clk)
    begin
        len1_reg <= LEN_W'(in_stage.root)
                  + LEN_W'(in_stage.rem > REM_W'(in_stage.root));
        sel1_reg <= (in_side.mode == MODE_AZIMUTH) ? TURN_QUARTER - theta : theta;
        sd1_reg  <= in_side;
    end

    // Scale the binary angle by pi/8 and by 45/128.
    always_ff @(posedge clk)
    begin
        prad_reg <= (2*ANG_W)'(sel1_reg) * (2*ANG_W)'(PI_Q30);
        pdeg_reg <= 38'(sel1_reg) * 38'(DEG_MUL);
        len2_reg <= len1_reg;
        sd2_reg  <= sd1_reg;
    end

    // Round to nearest and apply the special cases.
    logic [2*ANG_W:0] rad_sum;
    logic [37:0]      deg_sum;
    logic             ang_on;
    vla_out_t         res_next;

    always_comb
    begin
        rad_sum = (2*ANG_W+1)'(prad_reg) + ((2*ANG_W+1)'(1) << 32);
        deg_sum = pdeg_reg + 38'd64;
        ang_on  = !sd2_reg.degen
                && (sd2_reg.mode == MODE_AZIMUTH || sd2_reg.mode == MODE_EAST);
        res_next.length        = sd2_reg.degen ? LEN_W'(1) : len2_reg;
        res_next.angle_radians = ang_on ? rad_sum[63:33] : '0;
        res_next.angle_degrees = ang_on ? deg_sum[37:7] : '0;
        res_next.degenerate    = sd2_reg.degen;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = v3_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

### rtl/vla_checker.sv
// Port checker for the vector length and azimuth block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module vla_port_checker
    import vla_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     cfg_ready,
    input wire logic     done,
    input wire vla_out_t result
);

    // The block never refuses a beat or a mode write.
    `VLA_ASSERT(a_never_busy, !busy && cfg_ready, "block refused a beat")

    // Every accepted beat gives a result after the fixed latency.
    `VLA_ASSERT_IMP(a_beat_done, start && !busy, ##LATENCY done, "result lost")

    // No result appears without a beat accepted one latency earlier.
    `VLA_ASSERT_IMP(a_done_src, done, $past(start && !busy, LATENCY), "result invented")

    // Identical points give unit length and zero angles.
    `VLA_ASSERT_IMP(a_degen, done && result.degenerate, result.length == 1 && result.angle_radians == 0 && result.angle_degrees == 0, "bad degenerate result")

endmodule

bind vector_length_azimuth_2d vla_port_checker u_vla_checker (.*);

`default_nettype wire

### sim/vla_checker.sv
// Checker that predicts each result beat of the vector length block and compares it.
`default_nettype none

module vla_checker
    import vla_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire vla_in_t    item,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [1:0] cfg_data,
    input  wire logic       done,
    input  wire vla_out_t   result,
    output int              fails,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0] mode_copy;
    vla_out_t   expected_beats [$];

    initial fails = 0;
    assign pending = expected_beats.size();

    // One line per mismatch, and the count goes up.
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    // Rounded Euclidean length of (a, b) by a bitwise integer square root.
    function automatic logic [LEN_W-1:0] rounded_length(input logic [32:0] a,
                                                        input logic [32:0] b);
        logic [129:0] sq;
        logic [129:0] t;
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        sq = 130'(a) * 130'(a) + 130'(b) * 130'(b);
        for (int bit_pos = 32; bit_pos >= 0; bit_pos--)
        begin
            c = r | (64'd1 << bit_pos);
            t = 130'(c) * 130'(c);
            if (t <= sq)
                r = c;
        end
        // Round to nearest: step up when the sum lies beyond r*(r+1).
        t = 130'(r) * 130'(r + 64'd1);
        if (sq > t)
            r = r + 1;
        return r[LEN_W-1:0];
    endfunction

    // Vectoring rotation giving atan2(dy, dx) as a binary angle.
    function automatic logic [ANG_W-1:0] binary_angle(input longint dx_in, input longint dy_in);
        logic [ANG_W-1:0] z;
        logic [63:0]      ax;
        logic [63:0]      ay;
        logic [63:0]      m;
        longint           dx;
        longint           dy;
        longint           x;
        longint           y;
        longint           xs;
        longint           ys;
        bit               yneg;
        int               sh;
        dx = dx_in;
        dy = dy_in;
        z = 0;
        sh = 0;
        // Fold the left half plane onto the right one.
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
            z = TURN_HALF;
        end
        ax = dx;
        yneg = dy < 0;
        ay = yneg ? -dy : dy;
        m = (ax > ay) ? ax : ay;
        while (m != 0 && m < (64'd1 << NORM_BIT))
        begin
            m = m << 1;
            sh++;
        end
        x = ax << sh;
        y = ay << sh;
        if (yneg)
            y = -y;
        for (int i = 0; i < CORDIC_STAGES && i < 40; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        return z;
    endfunction

    // Full expected result beat for one input beat under the current mode.
    function automatic vla_out_t predict_beat(input vla_in_t v, input logic [1:0] m);
        vla_out_t         o;
        longint           dx;
        longint           dy;
        logic [ANG_W-1:0] theta;
        logic [ANG_W-1:0] sel;
        logic [65:0]      prod;
        dx = longint'(v.x_end) - longint'(v.x_start);
        dy = longint'(v.y_end) - longint'(v.y_start);
        o = '0;
        if (dx == 0 && dy == 0)
        begin
            o.length = 1;
            o.degenerate = 1'b1;
            return o;
        end
        o.length = rounded_length(33'(dx < 0 ? -dx : dx), 33'(dy < 0 ? -dy : dy));
        if (m != MODE_AZIMUTH && m != MODE_EAST)
            return o;
        // A vertical vector has an exact angle.
        if (dx == 0)
            theta = (dy < 0) ? TURN_3QUART : TURN_QUARTER;
        else
            theta = binary_angle(dx, dy);
        sel = (m == MODE_AZIMUTH) ? TURN_QUARTER - theta : theta;
        prod = (66'(sel) * 66'(PI_Q30) + (66'd1 << 32)) >> 33;
        o.angle_radians = prod[OUT_ANG_W-1:0];
        prod = (66'(sel) * 66'(DEG_MUL) + 66'd64) >> 7;
        o.angle_degrees = prod[OUT_ANG_W-1:0];
        return o;
    endfunction

    // Track the mode register and queue an expectation for each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_copy <= MODE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mode_copy <= cfg_data;
            if (start && !busy)
                expected_beats.push_back(predict_beat(item, mode_copy));
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        vla_out_t want;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("MISMATCH unexpected result beat");
                fails++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result.length !== want.length)
                    report("length", 64'(result.length), 64'(want.length));
                if (result.angle_radians !== want.angle_radians)
                    report("angle_radians", 64'(result.angle_radians), 64'(want.angle_radians));
                if (result.angle_degrees !== want.angle_degrees)
                    report("angle_degrees", 64'(result.angle_degrees), 64'(want.angle_degrees));
                if (result.degenerate !== want.degenerate)
                    report("degenerate", 64'(result.degenerate), 64'(want.degenerate));
            end
        end
    end

endmodule

`default_nettype wire

### sim/vector_length_azimuth_2d_tb.sv
// Testbench top that drives point pairs and mode writes into the block and gives the verdict.
`default_nettype none

module vector_length_azimuth_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vla_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    vla_in_t    item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       done;
    vla_out_t   result;
    int         fails;
    int         pending;
    int         cycles;
    bit         no_gaps;

    vector_length_azimuth_2d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    vla_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .result(result), .fails(fails), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Timeout guard.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector_length_azimuth_2d_tb failed");
            $finish;
        end
    end

    // Idle gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Send one beat; start stays high when no gap follows.
    task automatic send_beat(input vla_in_t v);
        int gap;
        start <= 1'b1;
        item <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write the mode register once the pipeline has drained.
    task automatic write_mode(input logic [1:0] m);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= $urandom_range(3);
    endtask

    // Random coordinate from a mix of full range, small values and extremes.
    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return $urandom;
        if (r < 8)
            return $signed(32'($urandom_range(4000))) - 2000;
        if (r == 8)
            return 32'h7FFF_FFFF - $urandom_range(3);
        return 32'h8000_0000 + $urandom_range(3);
    endfunction

    function automatic vla_in_t rand_beat();
        vla_in_t v;
        int r;
        v.x_start = rand_coord();
        v.y_start = rand_coord();
        v.x_end = rand_coord();
        v.y_end = rand_coord();
        r = $urandom_range(19);
        // Identical points, vertical and horizontal vectors now and then.
        if (r == 0)
        begin
            v.x_end = v.x_start;
            v.y_end = v.y_start;
        end
        else if (r < 3)
            v.x_end = v.x_start;
        else if (r < 5)
            v.y_end = v.y_start;
        return v;
    endfunction

    function automatic vla_in_t mk(input logic signed [31:0] xs, input logic signed [31:0] ys,
                                   input logic signed [31:0] xe, input logic signed [31:0] ye);
        vla_in_t v;
        v.x_start = xs;
        v.y_start = ys;
        v.x_end = xe;
        v.y_end = ye;
        return v;
    endfunction

    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;

    initial
    begin
        logic [1:0] modes [5];
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset mode (azimuth).
        send_beat(mk(0, 0, 0, 0));
        send_beat(mk(PMAX, PMIN, PMAX, PMIN));
        send_beat(mk(5, 7, 5, 100));
        send_beat(mk(5, 100, 5, 7));
        send_beat(mk(0, 0, 256, 0));
        send_beat(mk(0, 0, -256, 0));
        send_beat(mk(0, 0, 256, 256));
        send_beat(mk(0, 0, -256, -256));
        send_beat(mk(0, 0, 256, -256));
        send_beat(mk(0, 0, -256, 256));
        send_beat(mk(PMIN, PMIN, PMAX, PMAX));
        send_beat(mk(PMAX, PMAX, PMIN, PMIN));
        send_beat(mk(PMIN, PMAX, PMAX, PMIN));
        send_beat(mk(PMIN, 0, PMAX, 0));
        send_beat(mk(0, PMIN, 0, PMAX));
        send_beat(mk(0, PMAX, 0, PMIN));
        send_beat(mk(0, 0, 1, 0));
        send_beat(mk(0, 0, 0, -1));
        send_beat(mk(0, 0, 3, 4));
        send_beat(mk(0, 0, 1, 1));
        send_beat(mk(-1, -1, 0, 0));
        send_beat(mk(0, 0, -1, 1));

        // Random phases across every mode, the unused one too.
        modes = '{MODE_LENGTH, MODE_EAST, 2'd3, MODE_AZIMUTH, MODE_EAST};
        foreach (modes[p])
        begin
            write_mode(modes[p]);
            for (int n = 0; n < 100; n++)
            begin
                if (n % 25 == 0)
                    no_gaps = ($urandom_range(3) == 0);
                send_beat(rand_beat());
            end
            no_gaps = 1'b0;
        end

        // Drain and allow for the pipeline depth.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("vector_length_azimuth_2d_tb passed");
        else
            $display("vector_length_azimuth_2d_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
